// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertions used by the RTL of the vertical reflect convolution.
// ----------------------------------------------------------------------------
// Each macro expects clk and arst_n to be visible in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VCR_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VCR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/vcr_pkg.sv =====
// ----------------------------------------------------------------------------
// vcr_pkg
// Types and fixed constants of the vertical reflect convolution.
// ----------------------------------------------------------------------------
`default_nettype none

package vcr_pkg;

	localparam int COEF_W     = 16;
	localparam int TAP_SLOTS  = 7;
	localparam int LO_TAPS    = 4;
	localparam int HI_TAPS    = 3;
	localparam int ROW_W      = 12;
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 13;
	localparam int KSIZE_W    = 3;
	localparam int OUT_COL_W  = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int TAPS_HI_W  = 48;
	localparam int FRAC_BITS  = 14;
	localparam int ROUND_HALF = 8192;

	localparam logic [HEIGHT_W-1:0] MIN_HEIGHT = 13'd8;
	localparam logic [HEIGHT_W-1:0] MAX_HEIGHT = 13'd4096;

	localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 11'd1024;
	localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 13'd480;
	localparam logic [KSIZE_W-1:0]  RST_KSIZE  = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TAPS_LOW     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TAPS_HIGH    = 3'd4;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_MAC,
		S_EMIT
	} vcr_state_t;

endpackage

`default_nettype wire

// ===== sv/vertical_convolution_reflect.sv =====
// ----------------------------------------------------------------------------
// vertical_convolution_reflect
// Vertical pass of a separable blur with reflect-101 borders.
// ----------------------------------------------------------------------------
// Pixels enter in raster order and the line store keeps, for each column, one
// word holding the last MAX_TAPS-1 rows; it is read when a pixel is accepted
// and written back with that pixel in the following cycle, so the store needs
// no clearing pass after reset. A pixel produces no result, one result, or
// pad+1 results if it lies in the last row, and the input is stalled until
// they are done, because a single multiply-accumulate unit steps through the
// taps of the kernel in use one tap per cycle, and each result then waits in
// the emit state to enter the output register. Stalls on the output hold it
// there. Results are held in an output register, so a pixel may be accepted
// while the last result of the previous one is still waiting.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module vertical_convolution_reflect
	import vcr_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_TAPS   = 7,
	parameter int PIXEL_BITS = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [PIXEL_BITS-1:0] pixel,

	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [PIXEL_BITS-1:0]      blurred_value,
	output logic [ROW_W-1:0]           out_row,
	output logic [OUT_COL_W-1:0]       out_col,
	output logic                       last_of_run,
	output logic                       frame_done,

	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int STORE_ROWS = MAX_TAPS - 1;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int SLOT_W     = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;
	localparam int WORD_W     = STORE_ROWS * PIXEL_BITS;
	localparam int WB         = ($clog2(MAX_WIDTH + 1) > WIDTH_W) ?
	                            $clog2(MAX_WIDTH + 1) : WIDTH_W;
	localparam int PROD_W     = COEF_W + PIXEL_BITS + 1;
	localparam int ACC_W      = PROD_W + 3;

	localparam logic [WB-1:0]         MAX_W_C = WB'(MAX_WIDTH);
	localparam logic [PIXEL_BITS-1:0] PIX_MAX = '1;

	// Configuration registers.
	logic [WIDTH_W-1:0]    width_q;
	logic [HEIGHT_W-1:0]   height_q;
	logic [KSIZE_W-1:0]    ksize_q;
	logic [CFG_DATA_W-1:0] taps_lo_q;
	logic [TAPS_HI_W-1:0]  taps_hi_q;

	// Position of the next pixel.
	logic [COL_W-1:0]  col_cnt_q;
	logic [ROW_W-1:0]  row_cnt_q;
	logic [SLOT_W-1:0] slot_cnt_q;

	// The pixel being worked on.
	logic [PIXEL_BITS-1:0] pix_q;
	logic [COL_W-1:0]      col_q;
	logic [ROW_W-1:0]      row_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [KSIZE_W-1:0]    k_q;
	logic [1:0]            pad_q;
	logic                  last_row_q;
	logic                  row_end_q;
	logic                  has_out_q;
	logic [ROW_W-1:0]      q_q;
	logic [ROW_W-1:0]      q_last_q;
	logic [KSIZE_W-1:0]    tap_q;
	logic signed [ACC_W-1:0] acc_q;

	// Line store.
	logic [WORD_W-1:0] mem [MAX_WIDTH];
	logic [WORD_W-1:0] rd_word_q;
	logic [WORD_W-1:0] wr_word_c;

	// Output register.
	logic                  out_valid_q;
	logic [PIXEL_BITS-1:0] blur_q;
	logic [ROW_W-1:0]      row_out_q;
	logic [OUT_COL_W-1:0]  col_out_q;
	logic                  last_out_q;
	logic                  done_out_q;

	vcr_state_t state_q, state_d;

	logic                  in_acc;
	logic                  emit_go;
	logic [WB-1:0]         w_used_c;
	logic [HEIGHT_W-1:0]   h_used_c;
	logic [KSIZE_W-1:0]    k_c;
	logic [1:0]            pad_c;
	logic                  row_end_c;
	logic                  last_row_c;
	logic [ROW_W-1:0]      q_first_c;

	logic signed [ROW_W+1:0] r_raw_c, r_ref_c, row_s_c, d_full_c;
	logic [2:0]              d_c;
	logic signed [4:0]       sd_c;
	logic [SLOT_W-1:0]       src_slot_c;
	logic [PIXEL_BITS-1:0]   sample_c;
	logic signed [COEF_W-1:0] coef_c [TAP_SLOTS];
	logic signed [PROD_W-1:0] prod_c;
	logic signed [ACC_W-1:0]  acc_next_c;
	logic signed [ACC_W-1:0]  rsum_c, rshift_c;
	logic [PIXEL_BITS-1:0]    blur_c;
	logic [COL_W+OUT_COL_W-1:0] col_ext_c;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= RST_WIDTH;
			height_q  <= RST_HEIGHT;
			ksize_q   <= RST_KSIZE;
			taps_lo_q <= '0;
			taps_hi_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q   <= cfg_data[WIDTH_W-1:0];
				CFG_IMAGE_HEIGHT: height_q  <= cfg_data[HEIGHT_W-1:0];
				CFG_KERNEL_SIZE:  ksize_q   <= cfg_data[KSIZE_W-1:0];
				CFG_TAPS_LOW:     taps_lo_q <= cfg_data;
				CFG_TAPS_HIGH:    taps_hi_q <= cfg_data[TAPS_HI_W-1:0];
				default: ;
			endcase
		end
	end

	// Settings in use for the pixel at the input.
	always_comb begin
		w_used_c = WB'(width_q);
		if (w_used_c == '0) begin
			w_used_c = WB'(1);
		end else if (w_used_c > MAX_W_C) begin
			w_used_c = MAX_W_C;
		end
		h_used_c = height_q;
		if (h_used_c < MIN_HEIGHT) begin
			h_used_c = MIN_HEIGHT;
		end else if (h_used_c > MAX_HEIGHT) begin
			h_used_c = MAX_HEIGHT;
		end
		k_c = ksize_q;
		if (k_c > KSIZE_W'(MAX_TAPS)) begin
			k_c = KSIZE_W'(MAX_TAPS);
		end
		if (k_c == '0) begin
			k_c = KSIZE_W'(1);
		end
		if (!k_c[0]) begin
			k_c = k_c - KSIZE_W'(1);
		end
		pad_c      = k_c[2:1];
		row_end_c  = WB'(col_cnt_q) >= (w_used_c - WB'(1));
		last_row_c = {1'b0, row_cnt_q} >= (h_used_c - HEIGHT_W'(1));
		q_first_c  = row_cnt_q - ROW_W'(pad_c);
	end

	// Source row of the current tap, reflected at both borders, and its sample.
	always_comb begin
		row_s_c = signed'((ROW_W + 2)'(row_q));
		r_raw_c = signed'((ROW_W + 2)'(q_q)) - signed'((ROW_W + 2)'(pad_q))
		          + signed'((ROW_W + 2)'(tap_q));
		if (r_raw_c < 0) begin
			r_ref_c = -r_raw_c;
		end else begin
			r_ref_c = r_raw_c;
		end
		if (last_row_q && (r_ref_c > row_s_c)) begin
			r_ref_c = (row_s_c <<< 1) - r_ref_c;
		end
		if (r_ref_c < 0) begin
			r_ref_c = '0;
		end
		d_full_c = row_s_c - r_ref_c;
		d_c      = d_full_c[2:0];
		sd_c     = signed'(5'(slot_q)) - signed'(5'(d_c));
		if (sd_c < 0) begin
			sd_c = sd_c + signed'(5'(STORE_ROWS));
		end
		src_slot_c = sd_c[SLOT_W-1:0];
		sample_c   = rd_word_q[PIXEL_BITS-1:0];
		for (int i = 0; i < STORE_ROWS; i++) begin
			if (SLOT_W'(i) == src_slot_c) begin
				sample_c = rd_word_q[i*PIXEL_BITS +: PIXEL_BITS];
			end
		end
		if (d_c == '0) begin
			sample_c = pix_q;
		end
	end

	always_comb begin
		for (int i = 0; i < LO_TAPS; i++) begin
			coef_c[i] = taps_lo_q[i*COEF_W +: COEF_W];
		end
		for (int i = 0; i < HI_TAPS; i++) begin
			coef_c[i+LO_TAPS] = taps_hi_q[i*COEF_W +: COEF_W];
		end
		prod_c     = coef_c[tap_q] * signed'({1'b0, sample_c});
		acc_next_c = acc_q + ACC_W'(prod_c);
	end

	// Rounding half up from Q1.14 and saturation.
	always_comb begin
		rsum_c   = acc_q + signed'(ACC_W'(ROUND_HALF));
		rshift_c = rsum_c >>> FRAC_BITS;
		if (rsum_c <= 0) begin
			blur_c = '0;
		end else if (rshift_c > signed'(ACC_W'(PIX_MAX))) begin
			blur_c = PIX_MAX;
		end else begin
			blur_c = rshift_c[PIXEL_BITS-1:0];
		end
		col_ext_c = {{OUT_COL_W{1'b0}}, col_q};
	end

	always_comb begin
		wr_word_c = rd_word_q;
		for (int i = 0; i < STORE_ROWS; i++) begin
			if (SLOT_W'(i) == slot_q) begin
				wr_word_c[i*PIXEL_BITS +: PIXEL_BITS] = pix_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_word_q <= mem[col_cnt_q];
		end
		if (state_q == S_LOAD) begin
			mem[col_q] <= wr_word_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		in_acc   = 1'b0;
		emit_go  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				in_acc   = in_valid;
				if (in_valid) begin
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				state_d = has_out_q ? S_MAC : S_IDLE;
			end
			S_MAC: begin
				if (tap_q == (k_q - KSIZE_W'(1))) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				emit_go = !out_valid_q || !out_stall;
				if (emit_go) begin
					state_d = (q_q == q_last_q) ? S_IDLE : S_MAC;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q  <= '0;
			row_cnt_q  <= '0;
			slot_cnt_q <= '0;
		end else if (in_acc) begin
			if (row_end_c) begin
				col_cnt_q <= '0;
				if (last_row_c) begin
					row_cnt_q  <= '0;
					slot_cnt_q <= '0;
				end else begin
					row_cnt_q  <= row_cnt_q + ROW_W'(1);
					slot_cnt_q <= (slot_cnt_q == SLOT_W'(STORE_ROWS - 1)) ?
					              '0 : slot_cnt_q + SLOT_W'(1);
				end
			end else begin
				col_cnt_q <= col_cnt_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_q      <= pixel;
			col_q      <= col_cnt_q;
			row_q      <= row_cnt_q;
			slot_q     <= slot_cnt_q;
			k_q        <= k_c;
			pad_q      <= pad_c;
			last_row_q <= last_row_c;
			row_end_q  <= row_end_c;
			has_out_q  <= row_cnt_q >= ROW_W'(pad_c);
			q_q        <= q_first_c;
			q_last_q   <= last_row_c ? row_cnt_q : q_first_c;
			tap_q      <= '0;
			acc_q      <= '0;
		end else if (state_q == S_MAC) begin
			acc_q <= acc_next_c;
			tap_q <= tap_q + KSIZE_W'(1);
		end else if (emit_go) begin
			q_q   <= q_q + ROW_W'(1);
			tap_q <= '0;
			acc_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			blur_q     <= blur_c;
			row_out_q  <= q_q;
			col_out_q  <= col_ext_c[OUT_COL_W-1:0];
			last_out_q <= q_q == q_last_q;
			done_out_q <= (q_q == q_last_q) && last_row_q && row_end_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign blurred_value = blur_q;
	assign out_row       = row_out_q;
	assign out_col       = col_out_q;
	assign last_of_run   = last_out_q;
	assign frame_done    = done_out_q;

	`VCR_ASSERT_NEXT(a_load_after_accept, in_acc, state_q == S_LOAD,
		"Accepted transaction was not followed by the line store write-back.")
	`VCR_ASSERT_IMPL(a_output_from_emit, $rose(out_valid_q), $past(state_q) == S_EMIT,
		"Output became valid without a result being emitted.")
	`VCR_ASSERT_IMPL(a_done_is_last, out_valid_q && done_out_q, last_out_q,
		"End of frame flagged on a result that does not end its run.")
	`VCR_ASSERT_IMPL(a_tap_in_range, state_q == S_MAC, tap_q < k_q,
		"Tap counter ran past the kernel size in use.")

endmodule

`default_nettype wire

// ===== bench/vertical_convolution_reflect_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Result checker for the vertical reflect convolution
// Watches the pixel, result and register channels, keeps its own copy of the
// line store, counters and register values, predicts every blurred value of
// each accepted pixel and compares the results in order as they leave.
// ----------------------------------------------------------------------------

module vertical_convolution_reflect_checker
	import vcr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_stall,
	input  wire logic [7:0]            pixel,
	input  wire logic                  out_valid,
	input  wire logic                  out_stall,
	input  wire logic [7:0]            blurred_value,
	input  wire logic [ROW_W-1:0]      out_row,
	input  wire logic [OUT_COL_W-1:0]  out_col,
	input  wire logic                  last_of_run,
	input  wire logic                  frame_done,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         fail_count,
	output int                         pending
);

	localparam int LINE_LEN    = 1024;
	localparam int LINE_SLOTS  = TAP_SLOTS - 1;
	localparam int PIX_MAX     = 255;
	localparam int REPORT_CAP  = 50;

	typedef struct packed {
		logic [7:0]           value;
		logic [ROW_W-1:0]     row;
		logic [OUT_COL_W-1:0] col;
		logic                 last_flag;
		logic                 done_flag;
	} blur_result_t;

	logic [7:0]            line_mem [0:LINE_SLOTS*LINE_LEN-1];
	logic [WIDTH_W-1:0]    cur_width;
	logic [HEIGHT_W-1:0]   cur_height;
	logic [KSIZE_W-1:0]    cur_ksize;
	logic [CFG_DATA_W-1:0] cur_taps_lo;
	logic [TAPS_HI_W-1:0]  cur_taps_hi;
	int                    col_pos;
	int                    row_pos;
	blur_result_t          blurred_q [$];

	function automatic int tap_weight(input int t);
		logic [COEF_W*TAP_SLOTS-1:0] bank;
		bank = {cur_taps_hi, cur_taps_lo};
		return int'($signed(bank[COEF_W*t +: COEF_W]));
	endfunction

	function automatic logic [7:0] column_sum(input int q, input int pad, input int k,
			input bit bottom, input int cur_row, input int col, input logic [7:0] pix);
		longint acc;
		int     r;
		int     t;
		int     sample;
		acc = 0;
		for (t = 0; t < k; t++) begin
			r = q - pad + t;
			if (r < 0)
				r = -r;
			if (bottom && r > cur_row)
				r = 2 * cur_row - r;
			if (r < 0)
				r = 0;
			if (r == cur_row)
				sample = pix;
			else
				sample = line_mem[(r % LINE_SLOTS) * LINE_LEN + (col % LINE_LEN)];
			acc += longint'(tap_weight(t)) * longint'(sample);
		end
		acc += ROUND_HALF;
		if (acc <= 0)
			return 8'd0;
		acc = acc >>> FRAC_BITS;
		if (acc > PIX_MAX)
			return 8'(PIX_MAX);
		return 8'(acc);
	endfunction

	task automatic predict_pixel(input logic [7:0] pix);
		int           wu;
		int           hu;
		int           k;
		int           pad;
		int           q;
		int           first_q;
		int           last_q;
		bit           row_end;
		bit           last_row;
		blur_result_t res;
		wu = (cur_width < 1) ? 1 : ((cur_width > LINE_LEN) ? LINE_LEN : int'(cur_width));
		hu = (cur_height < MIN_HEIGHT) ? int'(MIN_HEIGHT) :
			((cur_height > MAX_HEIGHT) ? int'(MAX_HEIGHT) : int'(cur_height));
		k = (cur_ksize > TAP_SLOTS) ? TAP_SLOTS : int'(cur_ksize);
		if (k == 0)
			k = 1;
		if (k % 2 == 0)
			k--;
		pad = (k - 1) / 2;
		row_end = col_pos >= wu - 1;
		last_row = row_pos >= hu - 1;
		if (row_pos >= pad) begin
			first_q = row_pos - pad;
			last_q = last_row ? row_pos : first_q;
			for (q = first_q; q <= last_q; q++) begin
				res.value = column_sum(q, pad, k, last_row, row_pos, col_pos, pix);
				res.row = q[ROW_W-1:0];
				res.col = col_pos[OUT_COL_W-1:0];
				res.last_flag = (q == last_q);
				res.done_flag = (q == last_q) && last_row && row_end;
				blurred_q.push_back(res);
			end
		end
		line_mem[(row_pos % LINE_SLOTS) * LINE_LEN + (col_pos % LINE_LEN)] = pix;
		if (row_end) begin
			col_pos = 0;
			row_pos = last_row ? 0 : row_pos + 1;
		end else begin
			col_pos++;
		end
	endtask

	task automatic compare_result();
		blur_result_t seen;
		blur_result_t want;
		seen = '{blurred_value, out_row, out_col, last_of_run, frame_done};
		if (blurred_q.size() == 0) begin
			if (fail_count < REPORT_CAP)
				$display("%0t: result value %0d row %0d col %0d last %0b done %0b with none expected",
					$time, seen.value, seen.row, seen.col, seen.last_flag, seen.done_flag);
			fail_count++;
		end else begin
			want = blurred_q.pop_front();
			if (seen !== want) begin
				if (fail_count < REPORT_CAP)
					$display("%0t: expected value %0d row %0d col %0d last %0b done %0b, got value %0d row %0d col %0d last %0b done %0b",
						$time, want.value, want.row, want.col, want.last_flag, want.done_flag,
						seen.value, seen.row, seen.col, seen.last_flag, seen.done_flag);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		int idx;
		if (!arst_n) begin
			for (idx = 0; idx < LINE_SLOTS * LINE_LEN; idx++)
				line_mem[idx] = 8'd0;
			cur_width = RST_WIDTH;
			cur_height = RST_HEIGHT;
			cur_ksize = RST_KSIZE;
			cur_taps_lo = '0;
			cur_taps_hi = '0;
			col_pos = 0;
			row_pos = 0;
			blurred_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_IMAGE_WIDTH:  cur_width = cfg_data[WIDTH_W-1:0];
					CFG_IMAGE_HEIGHT: cur_height = cfg_data[HEIGHT_W-1:0];
					CFG_KERNEL_SIZE:  cur_ksize = cfg_data[KSIZE_W-1:0];
					CFG_TAPS_LOW:     cur_taps_lo = cfg_data;
					CFG_TAPS_HIGH:    cur_taps_hi = cfg_data[TAPS_HI_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_pixel(pixel);
			if (out_valid && !out_stall)
				compare_result();
			pending = blurred_q.size();
		end
	end

endmodule

// ===== bench/vertical_convolution_reflect_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the vertical reflect convolution
// Drives pixel frames in bursts under randomly stalled results, rewrites the
// registers between frames, and leaves the checking of results to the checker.
// ----------------------------------------------------------------------------

module vertical_convolution_reflect_tb;
	import vcr_pkg::*;

	localparam int HALF_PERIOD    = 5;
	localparam int SETTLE_CYCLES  = 16;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_ITEMS   = 310;
	localparam int HOLD_AFTER     = 100;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_TAPS_HIGH + 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = '1;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	typedef enum int {
		TAPS_SMOOTH,
		TAPS_ANY,
		TAPS_CORNER,
		TAPS_MIXED
	} tap_style_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [7:0]            pixel = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [7:0]            blurred_value;
	logic [ROW_W-1:0]      out_row;
	logic [OUT_COL_W-1:0]  out_col;
	logic                  last_of_run;
	logic                  frame_done;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    fail_count;
	int                    pending;
	bit                    hold_ask = 1'b0;
	bit                    hold_served = 1'b0;
	int                    burst_left = 0;

	always #HALF_PERIOD clk = ~clk;

	vertical_convolution_reflect dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel(pixel),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.blurred_value(blurred_value),
		.out_row(out_row),
		.out_col(out_col),
		.last_of_run(last_of_run),
		.frame_done(frame_done),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	vertical_convolution_reflect_checker result_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel(pixel),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.blurred_value(blurred_value),
		.out_row(out_row),
		.out_col(out_col),
		.last_of_run(last_of_run),
		.frame_done(frame_done),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending)
	);

	function automatic logic [7:0] pick_pixel();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return 8'($urandom);
	endfunction

	function automatic logic [COEF_W*TAP_SLOTS-1:0] pick_taps();
		logic [COEF_W*TAP_SLOTS-1:0] bank;
		logic [COEF_W-1:0]           corner [6];
		tap_style_t                  style;
		int                          t;
		corner = '{16'h7FFF, 16'h8000, 16'h0000, 16'h2000, 16'hE000, 16'h4000};
		style = tap_style_t'($urandom_range(0, 3));
		for (t = 0; t < TAP_SLOTS; t++) begin
			case (style)
				TAPS_SMOOTH: bank[COEF_W*t +: COEF_W] = 16'($urandom_range(0, 5000));
				TAPS_ANY:    bank[COEF_W*t +: COEF_W] = 16'($urandom);
				TAPS_CORNER: bank[COEF_W*t +: COEF_W] = corner[$urandom_range(0, 5)];
				default:     bank[COEF_W*t +: COEF_W] = 16'($urandom_range(0, 4000) - 1000);
			endcase
		end
		return bank;
	endfunction

	task automatic put_pixel(input logic [7:0] p);
		@(negedge clk);
		in_valid = 1'b1;
		pixel = p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic offer_pixel(input logic [7:0] p);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 8);
				@(negedge clk);
				in_valid = 1'b0;
				pixel = 8'($urandom);
				repeat (gap - 1)
					@(negedge clk);
			end
		end
		burst_left--;
		put_pixel(p);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic close_writes();
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_index = CFG_IDX_W'($urandom);
		cfg_data = {$urandom, $urandom};
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		pixel = 8'($urandom);
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic configure(input int w, input int h, input int k,
			input logic [CFG_DATA_W-1:0] lo, input logic [TAPS_HI_W-1:0] hi);
		logic [CFG_DATA_W-1:0] d;
		d = {$urandom, $urandom};
		d[WIDTH_W-1:0] = w[WIDTH_W-1:0];
		write_reg(CFG_IMAGE_WIDTH, d);
		d = {$urandom, $urandom};
		d[HEIGHT_W-1:0] = h[HEIGHT_W-1:0];
		write_reg(CFG_IMAGE_HEIGHT, d);
		d = {$urandom, $urandom};
		d[KSIZE_W-1:0] = k[KSIZE_W-1:0];
		write_reg(CFG_KERNEL_SIZE, d);
		write_reg(CFG_TAPS_LOW, lo);
		d = {$urandom, $urandom};
		d[TAPS_HI_W-1:0] = hi;
		write_reg(CFG_TAPS_HIGH, d);
		if ($urandom_range(0, 3) == 0)
			write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)), {$urandom, $urandom});
		close_writes();
	endtask

	initial begin : receiver
		stall_mode_t mode;
		int          seg;
		int          tick;
		tick = 0;
		wait (arst_n);
		forever begin
			mode = stall_mode_t'($urandom_range(0, 3));
			seg = $urandom_range(10, 80);
			repeat (seg) begin
				@(negedge clk);
				tick++;
				if (hold_ask && !hold_served) begin
					hold_served = 1'b1;
					out_stall = 1'b1;
					repeat (HOLD_CYCLES)
						@(negedge clk);
				end
				case (mode)
					STALL_NONE:     out_stall = 1'b0;
					STALL_LIGHT:    out_stall = ($urandom_range(0, 3) == 0);
					STALL_HEAVY:    out_stall = ($urandom_range(0, 9) < 7);
					default:        out_stall = (tick % 4 == 0);
				endcase
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		logic [COEF_W*TAP_SLOTS-1:0] taps;
		logic [7:0]                  probe_column [8];
		int                          w_reg;
		int                          h_reg;
		int                          k_reg;
		int                          wu;
		int                          hu;
		int                          random_done;
		probe_column = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd128, 8'd1, 8'd254, 8'd255};
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Widest and tallest frame, left part-way through by shrinking it.
		configure(2047, 4096, 0, 64'h8000_8000_8000_7FFF, 48'hFFFF_FFFF_FFFF);
		repeat (3)
			offer_pixel(pick_pixel());
		settle();
		write_reg(CFG_IMAGE_WIDTH, 64'd1024);
		write_reg(CFG_IMAGE_HEIGHT, 64'h1FFF);
		close_writes();
		repeat (3)
			offer_pixel(pick_pixel());
		settle();
		write_reg(CFG_IMAGE_WIDTH, 64'd0);
		write_reg(CFG_IMAGE_HEIGHT, 64'd0);
		close_writes();
		repeat (8)
			offer_pixel(pick_pixel());
		settle();

		// One column, seven taps: silent top rows, reflected borders, full last row.
		configure(1, 8, 7, {16'd5120, 16'd3840, 16'd1536, 16'd256}, {16'd256, 16'd1536, 16'd3840});
		foreach (probe_column[i])
			offer_pixel(probe_column[i]);
		settle();

		random_done = 0;
		while (random_done < RANDOM_ITEMS) begin
			w_reg = $urandom_range(0, 10);
			if (!hold_ask && random_done >= HOLD_AFTER)
				w_reg = 8;
			h_reg = ($urandom_range(0, 5) == 0) ? $urandom_range(12, 20) : $urandom_range(0, 11);
			k_reg = $urandom_range(0, 7);
			taps = pick_taps();
			configure(w_reg, h_reg, k_reg, taps[CFG_DATA_W-1:0], taps[COEF_W*TAP_SLOTS-1:CFG_DATA_W]);
			wu = (w_reg < 1) ? 1 : w_reg;
			hu = (h_reg < MIN_HEIGHT) ? int'(MIN_HEIGHT) : h_reg;
			if (!hold_ask && random_done >= HOLD_AFTER) begin
				hold_ask = 1'b1;
				burst_left = 60;
			end
			repeat (wu * hu)
				offer_pixel(pick_pixel());
			random_done += wu * hu;
			settle();
		end

		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/vcr_pkg.sv
sv/vertical_convolution_reflect.sv
bench/vertical_convolution_reflect_checker.sv
bench/vertical_convolution_reflect_tb.sv
